>>> rtl/vertex_dedup_table_top_macros.svh
// Assertion macros for the vertex dedup table
`ifndef VERTEX_DEDUP_TABLE_TOP_MACROS_SVH
`define VERTEX_DEDUP_TABLE_TOP_MACROS_SVH
// check that an antecedent implies a consequent on the same edge
`define VDT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// check that an antecedent implies a consequent on the next edge
`define VDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/vdt_pkg.sv
// Package: types and constants for the vertex dedup table
`timescale 1ns / 1ps
package vdt_pkg;
   localparam int TableDepth = 1024;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);
   localparam int EntryW = 256;
   localparam int OutIdxW = 10;

   typedef struct packed {
      logic        mesh_start;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] norm_x;
      logic [31:0] norm_y;
      logic [31:0] norm_z;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
   } req_type;

   typedef struct packed {
      logic [OutIdxW-1:0] vertex_index;
      logic               is_new;
      logic               overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;
endpackage

>>> rtl/vertex_dedup_table_top.sv
// Top level: sequential vertex dedup table with one shared entry comparator
// Operation: each stored entry is read and then compared in turn; the scan ends on a match,
// or past the last entry with an append or an overflow, and the result strobe follows.
// Throughput: one request at a time; busy stays high through the result strobe,
// so the next request is taken in the cycle after the strobe at the earliest.
// Reset: synchronous, clears the entry count and the sequencer; table
// contents are not cleared. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module vertex_dedup_table_top
   import vdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
`include "vertex_dedup_table_top_macros.svh"

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [EntryW-1:0] corner_ff, corner_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic wr_en, match, accept;
   logic [EntryW-1:0] rd_data, req_corner;

   assign req_corner = {req_data.tex_v, req_data.tex_u, req_data.norm_z, req_data.norm_y,
                        req_data.norm_x, req_data.pos_z, req_data.pos_y, req_data.pos_x};

   // take a request only when not busy, including the result strobe cycle
   assign accept = start && !busy;

   vdt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (idx_ff[IdxW-1:0]),
      .wr_data(corner_ff),
      .rd_data(rd_data)
   );

   vdt_cmp u_cmp (.entry(rd_data), .corner(corner_ff), .match(match));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: if (idx_ff >= count_ff) state_in = ST_DONE;
                  else state_in = ST_CMP;
         ST_CMP:  if (match) state_in = ST_DONE;
                  else state_in = ST_READ;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      idx_in = idx_ff;
      corner_in = corner_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               corner_in = req_corner;
               idx_in = '0;
               if (req_data.mesh_start) count_in = '0;
            end
         end
         ST_READ: begin
            if (idx_ff >= count_ff) begin
               if (count_ff == CntW'(TableDepth)) begin
                  rsp_in = '{vertex_index: '0, is_new: 1'b0, overflow: 1'b1};
               end else begin
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
                  rsp_in = '{vertex_index: OutIdxW'(idx_ff), is_new: 1'b1,
                             overflow: 1'b0};
               end
            end
         end
         ST_CMP: begin
            if (match) begin
               rsp_in = '{vertex_index: OutIdxW'(idx_ff), is_new: 1'b0, overflow: 1'b0};
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      corner_ff <= corner_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `VDT_ASSERT_SAME(a_count_cap, clock, reset, 1'b1, count_ff <= CntW'(TableDepth))
   `VDT_ASSERT_SAME(a_scan_bound, clock, reset, state_ff == ST_CMP, idx_ff < count_ff)
   `VDT_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == ST_DONE, rsp_valid)
   `VDT_ASSERT_SAME(a_rsp_flags, clock, reset, rsp_valid,
                    !(rsp_data.is_new && rsp_data.overflow))
endmodule

>>> rtl/vdt_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module vdt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> rtl/vdt_cmp.sv
// Float-rule equality compare of one stored entry against a corner
`timescale 1ns / 1ps
module vdt_cmp
   import vdt_pkg::*;
(
   input  logic [EntryW-1:0] entry,
   input  logic [EntryW-1:0] corner,
   output logic              match
);
   logic [7:0] eq;

   always_comb begin
      for (int w = 0; w < 8; w++) begin
         logic [31:0] a;
         logic [31:0] b;
         logic        nan_a;
         logic        nan_b;
         a = entry[w*32 +: 32];
         b = corner[w*32 +: 32];
         nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
         nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
         eq[w] = !nan_a && !nan_b && (((a[30:0] | b[30:0]) == 31'd0) || (a == b));
      end
   end

   assign match = &eq;
endmodule

>>> sim/tb_top.sv
// Testbench for the vertex dedup table: directed corners, a full-table fill and random meshes
`timescale 1ns / 1ps
module tb_top;
   import vdt_pkg::*;

   class dedup_scoreboard;
      logic [31:0] stored [TableDepth][8];
      int unsigned unique_count;
      rsp_type     due_results [$];
      int          errs;

      function new();
         unique_count = 0;
         errs = 0;
      endfunction

      static function bit is_nan(logic [31:0] w);
         return (w[30:23] == 8'hFF) && (w[22:0] != 0);
      endfunction

      static function bit float_eq(logic [31:0] a, logic [31:0] b);
         if (is_nan(a) || is_nan(b)) return 0;
         if (((a | b) & 32'h7FFF_FFFF) == 0) return 1;
         return a == b;
      endfunction

      // compute the index for one accepted request and queue it
      function void note_request(req_type r);
         logic [31:0] w [8];
         rsp_type     p;
         bit          hit;
         w = '{r.pos_x, r.pos_y, r.pos_z, r.norm_x, r.norm_y, r.norm_z, r.tex_u, r.tex_v};
         if (r.mesh_start) unique_count = 0;
         p = '0;
         hit = 0;
         for (int i = 0; i < unique_count && !hit; i++) begin
            hit = 1;
            for (int k = 0; k < 8; k++)
               if (!float_eq(stored[i][k], w[k])) hit = 0;
            if (hit) p.vertex_index = i[OutIdxW-1:0];
         end
         if (!hit) begin
            if (unique_count >= TableDepth) begin
               p.overflow = 1;
            end else begin
               for (int k = 0; k < 8; k++) stored[unique_count][k] = w[k];
               p.vertex_index = unique_count[OutIdxW-1:0];
               p.is_new = 1;
               unique_count++;
            end
         end
         due_results.push_back(p);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (due_results.size() == 0) begin
            $error("unexpected result: vertex_index %0d", a.vertex_index);
            errs++;
            return;
         end
         e = due_results.pop_front();
         if (a.vertex_index !== e.vertex_index) begin
            $error("vertex_index exp %0d got %0d", e.vertex_index, a.vertex_index);
            errs++;
         end
         if (a.is_new !== e.is_new) begin
            $error("is_new exp %0d got %0d", e.is_new, a.is_new);
            errs++;
         end
         if (a.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, a.overflow);
            errs++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   dedup_scoreboard sb = new();
   bit              no_gaps;
   longint          cycles = 0;
   req_type         mesh_corners [$];

   vertex_dedup_table_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 20_000_000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send(req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      if (r.mesh_start) mesh_corners.delete();
      mesh_corners.push_back(r);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 11))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         3: return {$urandom_range(0, 1) == 1, 31'h7F80_0000};
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_corner();
      req_type r;
      r = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
      if ($urandom_range(0, 3) != 0) begin
         r.pos_x = rand_word(); r.pos_y = rand_word(); r.pos_z = rand_word();
         r.norm_x = rand_word(); r.norm_y = rand_word(); r.norm_z = rand_word();
         r.tex_u = rand_word(); r.tex_v = rand_word();
      end
      return r;
   endfunction

   // flip the sign of zero words so the match must treat both zeros alike
   function automatic logic [31:0] flip_zero(logic [31:0] w);
      if ((w & 32'h7FFF_FFFF) == 0 && $urandom_range(0, 1)) return w ^ 32'h8000_0000;
      return w;
   endfunction

   initial begin
      req_type r;
      no_gaps = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zeros, sign of zero, NaN, infinities, all ones
      r = '0; r.mesh_start = 1; send(r);
      r = '0; send(r);
      r = '0; r.pos_x = 32'h8000_0000; r.tex_v = 32'h8000_0000; send(r);
      r = {1'b0, {8{32'hFFFF_FFFF}}}; send(r);
      send(r);
      r = {1'b0, {8{32'h7FC0_0000}}}; send(r);
      r = {1'b0, {8{32'h7F80_0000}}}; send(r);
      send(r);
      r = {1'b0, {8{32'hFF80_0000}}}; send(r);
      r = {1'b0, {8{32'h3F80_0000}}}; send(r);
      r.norm_z = 32'h7F80_0001; send(r);
      r = {1'b0, {8{32'h3F80_0000}}}; send(r);
      r = {1'b0, {8{32'h7FFF_FFFF}}}; send(r);
      r = '0; r.mesh_start = 1; send(r);
      r = {1'b0, {8{32'h8000_0000}}}; send(r);

      // fill the table to the last entry, then push past it
      for (int i = 0; i < TableDepth; i++) begin
         no_gaps = ((i / 64) % 2) == 1;
         r = {i == 0, {8{32'h3F80_0000 + i}}};
         send(r);
      end
      no_gaps = 0;
      for (int i = 0; i < 4; i++) send(rand_corner());
      r = {1'b0, {8{32'h3F80_0000 + TableDepth - 1}}}; send(r);
      r = {1'b0, {8{32'h3F80_0000 + 5}}}; send(r);
      r = {1'b0, {8{32'h3F80_0000}}}; send(r);

      // random meshes: about half repeats of earlier corners, the rest fresh ones
      for (int n = 0; n < 580; n++) begin
         no_gaps = (n / 40) % 3 == 1;
         if (mesh_corners.size() > 0 && $urandom_range(0, 1)) begin
            r = mesh_corners[$urandom_range(0, mesh_corners.size() - 1)];
            r.pos_x = flip_zero(r.pos_x); r.pos_y = flip_zero(r.pos_y);
            r.pos_z = flip_zero(r.pos_z); r.norm_x = flip_zero(r.norm_x);
            r.norm_y = flip_zero(r.norm_y); r.norm_z = flip_zero(r.norm_z);
            r.tex_u = flip_zero(r.tex_u); r.tex_v = flip_zero(r.tex_v);
         end else begin
            r = rand_corner();
         end
         r.mesh_start = ($urandom_range(0, 29) == 0);
         send(r);
      end
      start <= 0;

      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (2 * TableDepth + 10) @(posedge clock);
      if (sb.errs == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
